[sv/tbrl_pkg.sv]
package tbrl_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int DEPTH_WIDTH = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
  localparam int DIV_WIDTH   = (COUNT_WIDTH + 10 > 64) ? COUNT_WIDTH + 10 : 64;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [DIV_WIDTH-1:0]   div_word_t;
  typedef logic [0:0]             cfg_index_t;

  localparam cfg_index_t CFG_BUCKET_DEPTH = 1'b0;
  localparam cfg_index_t CFG_FILL_RATE    = 1'b1;

  localparam logic [31:0] DEPTH_RESET = 32'd65536;
  localparam logic [31:0] RATE_RESET  = 32'd1000;
  localparam logic [31:0] MS_PER_S    = 32'd1000;
  localparam logic [31:0] MAX32       = 32'hFFFF_FFFF;
  localparam count_t      COUNT_MAX   = '1;

  // floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for any x below 2^26
  localparam logic [26:0] RECIP_1000  = 27'd68719477;
  localparam int          RECIP_SHIFT = 36;

  // saturate the configured depth to the counter range
  function automatic count_t eff_depth(input logic [31:0] depth);
    logic [DEPTH_WIDTH-1:0] wide;
    wide = DEPTH_WIDTH'(depth);
    if (wide > DEPTH_WIDTH'(COUNT_MAX)) begin
      return COUNT_MAX;
    end
    return COUNT_WIDTH'(wide);
  endfunction

endpackage

[sv/tbrl_div.sv]
module tbrl_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  tbrl_pkg::div_word_t dividend,
  input  logic [31:0]         divisor,
  output logic                done,
  output tbrl_pkg::div_word_t quotient
);
  import tbrl_pkg::*;

  localparam int StepWidth = $clog2(DIV_WIDTH + 1);

  logic                 busy;
  logic [StepWidth-1:0] cnt;
  logic [31:0]          rem;
  logic [31:0]          den;
  logic [32:0]          rem_sh;
  logic                 fits;
  logic [31:0]          rem_next;

  assign rem_sh   = {rem, quotient[DIV_WIDTH-1]};
  assign fits     = rem_sh >= {1'b0, den};
  assign rem_next = fits ? 32'(rem_sh - {1'b0, den}) : rem_sh[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= StepWidth'(DIV_WIDTH);
        rem      <= '0;
        den      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= rem_next;
        quotient <= {quotient[DIV_WIDTH-2:0], fits};
        cnt      <= cnt - StepWidth'(1);
        if (cnt == StepWidth'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a running division");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("divider restarted mid-division");

  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != '0)
    else $error("divider busy with no steps left");

endmodule

[sv/token_bucket_rate_limiter.sv]
// Token bucket rate limiter.
// Item channel (item_valid / item_stall): op, now_ms, drain_length. op 0
// refills the bucket from the time elapsed since the last update, then
// grants the drain when drain_length fits; op 1 empties the bucket.
// Result channel (result_valid / result_stall): granted, tokens_left and
// fill_time_ms, one word per item, in order.
// Configuration: cfg_we writes cfg_data to bucket_depth (index 0) or
// fill_rate (index 1); write only while no item is in progress.
// One item at a time: item_stall stays high from acceptance until the
// result is loaded into the output register. A refill divides the
// rate-time product by 1000 in four 16-bit digits, each a quotient-digit
// step (S_QDIG) then a remainder step (S_RDIG), through a reciprocal
// multiply; the fill time uses the radix-2 divider, 64 steps. A zero rate
// skips the divider.
// The output register holds a word while result_stall is high and the next
// item is accepted meanwhile; its result waits in the sequencer until the
// register is free.
// Reset: bucket full at 65536 tokens, rate 1000 per second, last update 0.
module token_bucket_rate_limiter (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic                 op,
  input  logic [31:0]          now_ms,
  input  logic [31:0]          drain_length,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 granted,
  output logic [31:0]          tokens_left,
  output logic [31:0]          fill_time_ms,
  input  logic                 cfg_we,
  input  tbrl_pkg::cfg_index_t cfg_index,
  input  logic [31:0]          cfg_data
);
  import tbrl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_QDIG, S_RDIG, S_ADD, S_GRANT, S_FILL, S_DIVF, S_DONE
  } state_t;

  state_t      state;
  logic [31:0] bucket_depth;
  logic [31:0] fill_rate;
  count_t      tokens;
  logic [31:0] last_ms;
  logic [31:0] now_r;
  logic [31:0] len_r;
  logic [31:0] elapsed;
  logic        granted_r;
  logic [31:0] fill_r;
  logic        div_go;
  div_word_t   div_num;
  logic [31:0] div_den;
  logic        div_done;
  div_word_t   div_quo;
  logic [63:0] acc;
  logic [63:0] quo_ms;
  logic [9:0]  rem_ms;
  logic [15:0] q_dig;
  logic [1:0]  dig;

  count_t      depth;
  logic [63:0] prod;
  count_t      room;
  count_t      add_amt;
  count_t      missing;
  div_word_t   missing_ms;
  logic [25:0] cur;
  logic [51:0] recip_prod;

  assign depth      = eff_depth(bucket_depth);
  assign prod       = 64'(fill_rate) * 64'(elapsed);
  assign room       = depth - tokens;
  assign add_amt    = (quo_ms > 64'(room)) ? room : COUNT_WIDTH'(quo_ms);
  assign missing    = (tokens < depth) ? depth - tokens : '0;
  assign missing_ms = (DIV_WIDTH'(missing) << 10) - (DIV_WIDTH'(missing) << 4)
                    - (DIV_WIDTH'(missing) << 3);
  assign cur        = {rem_ms, acc[63:48]};
  assign recip_prod = 52'(cur) * 52'(RECIP_1000);
  assign item_stall = (state != S_IDLE);

  tbrl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      bucket_depth <= DEPTH_RESET;
      fill_rate    <= RATE_RESET;
      tokens       <= eff_depth(DEPTH_RESET);
      last_ms      <= '0;
      result_valid <= 1'b0;
      div_go       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BUCKET_DEPTH: bucket_depth <= cfg_data;
          CFG_FILL_RATE:    fill_rate    <= cfg_data;
          default:          ;
        endcase
      end
      if (result_valid && !result_stall && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            granted_r <= 1'b0;
            now_r     <= now_ms;
            len_r     <= drain_length;
            if (op) begin
              tokens  <= '0;
              last_ms <= now_ms;
              state   <= S_FILL;
            end else if (tokens >= depth) begin
              tokens  <= depth;
              last_ms <= now_ms;
              state   <= S_GRANT;
            end else begin
              elapsed <= now_ms - last_ms;
              state   <= S_MUL;
            end
          end
        end
        S_MUL: begin
          acc    <= prod;
          quo_ms <= '0;
          rem_ms <= '0;
          dig    <= 2'd3;
          state  <= S_QDIG;
        end
        S_QDIG: begin
          q_dig <= recip_prod[RECIP_SHIFT+15:RECIP_SHIFT];
          state <= S_RDIG;
        end
        S_RDIG: begin
          rem_ms <= 10'(cur - 26'(q_dig) * 26'(MS_PER_S));
          quo_ms <= {quo_ms[47:0], q_dig};
          acc    <= {acc[47:0], 16'h0000};
          dig    <= dig - 2'd1;
          if (dig == 2'd0) begin
            state <= S_ADD;
          end else begin
            state <= S_QDIG;
          end
        end
        S_ADD: begin
          if (quo_ms != '0) begin
            tokens  <= tokens + add_amt;
            last_ms <= now_r;
          end
          state <= S_GRANT;
        end
        S_GRANT: begin
          if (DEPTH_WIDTH'(len_r) <= DEPTH_WIDTH'(tokens)) begin
            tokens    <= tokens - COUNT_WIDTH'(len_r);
            granted_r <= 1'b1;
          end
          state <= S_FILL;
        end
        S_FILL: begin
          if (fill_rate == '0) begin
            fill_r <= MAX32;
            state  <= S_DONE;
          end else begin
            div_num <= missing_ms;
            div_den <= fill_rate;
            div_go  <= 1'b1;
            state   <= S_DIVF;
          end
        end
        S_DIVF: begin
          div_go <= 1'b0;
          if (div_done) begin
            fill_r <= (|div_quo[DIV_WIDTH-1:32]) ? MAX32 : div_quo[31:0];
            state  <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            granted      <= granted_r;
            tokens_left  <= 32'(tokens);
            fill_time_ms <= fill_r;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_DONE))
    else $error("result word loaded outside the final step");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIVF)
    else $error("division finished with no step waiting on it");

  a_grant_no_gain: assert property (@(posedge clk) disable iff (rst)
    state == S_GRANT |=> tokens <= $past(tokens))
    else $error("drain step added tokens");

endmodule
